// ===== rtl/hsps_pkg.sv =====
package hsps_pkg;

  // syntax steps of the sps header
  localparam logic [5:0] S_NAL     = 6'd0;
  localparam logic [5:0] S_PROFILE = 6'd1;
  localparam logic [5:0] S_CONSTR  = 6'd2;
  localparam logic [5:0] S_LEVEL   = 6'd3;
  localparam logic [5:0] S_SPSID   = 6'd4;
  localparam logic [5:0] S_CHROMA  = 6'd5;
  localparam logic [5:0] S_SEP     = 6'd6;
  localparam logic [5:0] S_DEPL    = 6'd7;
  localparam logic [5:0] S_DEPC    = 6'd8;
  localparam logic [5:0] S_BYPASS  = 6'd9;
  localparam logic [5:0] S_SMP     = 6'd10;
  localparam logic [5:0] S_LFLAG   = 6'd11;
  localparam logic [5:0] S_DELTA   = 6'd12;
  localparam logic [5:0] S_LOG2FN  = 6'd13;
  localparam logic [5:0] S_POCTYPE = 6'd14;
  localparam logic [5:0] S_POCLSB  = 6'd15;
  localparam logic [5:0] S_DZERO   = 6'd16;
  localparam logic [5:0] S_OFFNR   = 6'd17;
  localparam logic [5:0] S_OFFTB   = 6'd18;
  localparam logic [5:0] S_NCYC    = 6'd19;
  localparam logic [5:0] S_CYCOFF  = 6'd20;
  localparam logic [5:0] S_MAXREF  = 6'd21;
  localparam logic [5:0] S_GAPS    = 6'd22;
  localparam logic [5:0] S_WIDTH   = 6'd23;
  localparam logic [5:0] S_HEIGHT  = 6'd24;
  localparam logic [5:0] S_FMO     = 6'd25;
  localparam logic [5:0] S_MBAFF   = 6'd26;
  localparam logic [5:0] S_D8X8    = 6'd27;
  localparam logic [5:0] S_CROPF   = 6'd28;
  localparam logic [5:0] S_CROP0   = 6'd29;
  localparam logic [5:0] S_CROP1   = 6'd30;
  localparam logic [5:0] S_CROP2   = 6'd31;
  localparam logic [5:0] S_CROP3   = 6'd32;
  localparam logic [5:0] S_VUI     = 6'd33;
  localparam logic [5:0] S_DONE    = 6'd34;

  // bit reader modes
  localparam logic [1:0] RD_FIXED  = 2'd0;
  localparam logic [1:0] RD_PREFIX = 2'd1;
  localparam logic [1:0] RD_SUFFIX = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_SPS   = 3'd1;
  localparam logic [2:0] ST_BAD_PROF  = 3'd2;
  localparam logic [2:0] ST_BAD_LEVEL = 3'd3;
  localparam logic [2:0] ST_BAD_ID    = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_CODE_ERR  = 3'd6;

  localparam int          QUEUE_DEPTH = 4;
  localparam logic [12:0] MAX_DIM     = 13'd4096;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hsps_item_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [1:0]  chroma_format;
    logic [2:0]  status;
  } hsps_result_t;

  // fixed-length fields; zero means an exp-golomb code
  function automatic logic [4:0] fixed_bits(input logic [5:0] s);
    logic [4:0] n;
    n = 5'd0;
    unique case (s) inside
      S_NAL, S_PROFILE, S_CONSTR, S_LEVEL: n = 5'd8;
      S_SEP, S_BYPASS, S_SMP, S_LFLAG, S_DZERO, S_GAPS, S_FMO, S_MBAFF,
      S_D8X8, S_CROPF, S_VUI: n = 5'd1;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_high(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244;
  endfunction

  function automatic logic level_ok(input logic [7:0] v);
    logic ok;
    ok = 1'b0;
    unique case (v) inside
      8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd20, 8'd21, 8'd22,
      8'd30, 8'd31, 8'd32, 8'd40, 8'd41, 8'd42, 8'd50, 8'd51: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/hsps_queue.sv =====
module hsps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hsps_pkg::hsps_item_t push_item,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output hsps_pkg::hsps_item_t head_item
);
  import hsps_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  hsps_item_t     mem_r [QUEUE_DEPTH];
  logic [AW-1:0]  wptr_r, rptr_r;
  logic [AW:0]    count_r;

  assign not_full  = count_r != (AW+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head_item = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/hsps_bit_engine.sv =====
module hsps_bit_engine #(
  parameter int MAX_PIC_MBS   = 256,
  parameter int MAX_SPS_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  input  hsps_pkg::hsps_item_t   item,
  input  logic                   hold,
  output logic                   byte_done,
  output logic                   res_valid,
  output hsps_pkg::hsps_result_t res
);
  import hsps_pkg::*;

  logic [5:0]  step_r, step_n;
  logic [1:0]  mode_r, mode_n;
  logic [4:0]  cnt_r, cnt_n;
  logic [3:0]  zrun_r, zrun_n;
  logic [15:0] acc_r, acc_n;
  logic [7:0]  fcnt_r, fcnt_n;
  logic [3:0]  lidx_r, lidx_n;
  logic [6:0]  cidx_r, cidx_n;
  logic [7:0]  lscale_r, lscale_n;
  logic [15:0] wmbs_r, wmbs_n;
  logic [15:0] hunits_r, hunits_n;
  logic [15:0] crop_r [4];
  logic [15:0] crop_n [4];
  logic        fsep_r, fsep_n, ffmo_r, ffmo_n, fcrop_r, fcrop_n;
  logic        sent_r, sent_n;
  logic [7:0]  prof_r, prof_n, level_r, level_n;
  logic [1:0]  chroma_r, chroma_n;
  logic [2:0]  bidx_r, bidx_n;

  logic        run;
  logic        b;
  logic        fd;
  logic [15:0] v;
  logic        go;
  logic [5:0]  go_step;
  logic        emit;
  logic [2:0]  emit_st;
  logic [12:0] emit_w, emit_h;
  logic [7:0]  emit_prof, emit_level;
  logic [3:0]  lnext;
  logic [3:0]  lcount;
  logic [7:0]  delta, nscale;
  logic [6:0]  cnext;
  logic [16:0] hmbs;
  logic [20:0] wpix, hpix, sumx, sumy, cw, ch, wr, hr;
  logic        one_x;
  logic [1:0]  sh_y;
  logic [4:0]  fb;

  assign run = item_valid && !hold;
  assign b   = item.data_byte[~bidx_r];

  // crop arithmetic for the end of the header
  always_comb begin
    hmbs = ffmo_r ? {1'b0, hunits_r} : {hunits_r, 1'b0};
    wpix = {1'b0, wmbs_r, 4'b0};
    hpix = {hmbs, 4'b0};
    sumx = 21'(crop_r[0]) + 21'(crop_r[1]);
    sumy = 21'(crop_r[2]) + 21'(crop_r[3]);
    if (chroma_r == 2'd0 || fsep_r) begin
      one_x = 1'b1;
      sh_y  = ffmo_r ? 2'd0 : 2'd1;
    end else begin
      one_x = chroma_r == 2'd3;
      sh_y  = 2'(chroma_r == 2'd1) + (ffmo_r ? 2'd0 : 2'd1);
    end
    cw = fcrop_r ? (one_x ? sumx : {sumx[19:0], 1'b0}) : '0;
    ch = fcrop_r ? (sumy << sh_y) : '0;
    wr = wpix - cw;
    hr = hpix - ch;
  end

  // one bit of the header per cycle while an item is valid and not held
  always_comb begin
    step_n = step_r; mode_n = mode_r; cnt_n = cnt_r; zrun_n = zrun_r;
    acc_n = acc_r; fcnt_n = fcnt_r; lidx_n = lidx_r; cidx_n = cidx_r;
    lscale_n = lscale_r; wmbs_n = wmbs_r; hunits_n = hunits_r;
    for (int i = 0; i < 4; i++) crop_n[i] = crop_r[i];
    fsep_n = fsep_r; ffmo_n = ffmo_r; fcrop_n = fcrop_r; sent_n = sent_r;
    prof_n = prof_r; level_n = level_r; chroma_n = chroma_r; bidx_n = bidx_r;
    fd = 1'b0; v = '0; go = 1'b0; go_step = step_r;
    emit = 1'b0; emit_st = ST_OK; emit_w = '0; emit_h = '0;
    emit_prof = prof_r; emit_level = level_r;
    lcount = (chroma_r == 2'd3) ? 4'd12 : 4'd8;
    lnext = lidx_r + 1'b1;
    delta = '0; nscale = '0; cnext = '0;
    fb = '0;
    byte_done = 1'b0;

    if (run) begin
      // bit reader
      if (!sent_r) begin
        unique case (mode_r)
          RD_FIXED: begin
            acc_n = {acc_r[14:0], b};
            cnt_n = cnt_r - 1'b1;
            if (cnt_n == '0) begin fd = 1'b1; v = acc_n; end
          end
          RD_PREFIX: begin
            if (!b) begin
              if (zrun_r == 4'd15) begin emit = 1'b1; emit_st = ST_CODE_ERR; end
              else zrun_n = zrun_r + 1'b1;
            end else begin
              acc_n = 16'd1;
              if (zrun_r == '0) fd = 1'b1;
              else begin mode_n = RD_SUFFIX; cnt_n = {1'b0, zrun_r}; end
            end
          end
          default: begin
            acc_n = {acc_r[14:0], b};
            cnt_n = cnt_r - 1'b1;
            if (cnt_n == '0) begin fd = 1'b1; v = acc_n - 1'b1; end
          end
        endcase
      end

      // syntax decoder
      if (fd) begin
        unique case (step_r)
          S_NAL: begin
            if (v[4:0] != 5'd7) begin emit = 1'b1; emit_st = ST_NOT_SPS; end
            else begin go = 1'b1; go_step = S_PROFILE; end
          end
          S_PROFILE: begin
            prof_n = v[7:0];
            if (!(is_high(v[7:0]) || v[7:0] == 8'd66 || v[7:0] == 8'd77 ||
                  v[7:0] == 8'd88)) begin
              emit = 1'b1; emit_st = ST_BAD_PROF;
            end else begin go = 1'b1; go_step = S_CONSTR; end
          end
          S_CONSTR: begin go = 1'b1; go_step = S_LEVEL; end
          S_LEVEL: begin
            level_n = v[7:0];
            if (!level_ok(v[7:0])) begin emit = 1'b1; emit_st = ST_BAD_LEVEL; end
            else begin go = 1'b1; go_step = S_SPSID; end
          end
          S_SPSID: begin
            if (17'(v) > 17'(MAX_SPS_COUNT - 1)) begin
              emit = 1'b1; emit_st = ST_BAD_ID;
            end else begin
              go = 1'b1; go_step = is_high(prof_r) ? S_CHROMA : S_LOG2FN;
            end
          end
          S_CHROMA: begin
            if (v > 16'd3) begin emit = 1'b1; emit_st = ST_CODE_ERR; end
            else begin
              chroma_n = v[1:0];
              go = 1'b1; go_step = (v[1:0] == 2'd3) ? S_SEP : S_DEPL;
            end
          end
          S_SEP: begin
            if (v[0]) fsep_n = 1'b1;
            go = 1'b1; go_step = S_DEPL;
          end
          S_DEPL:   begin go = 1'b1; go_step = S_DEPC; end
          S_DEPC:   begin go = 1'b1; go_step = S_BYPASS; end
          S_BYPASS: begin go = 1'b1; go_step = S_SMP; end
          S_SMP: begin
            lidx_n = '0;
            go = 1'b1; go_step = v[0] ? S_LFLAG : S_LOG2FN;
          end
          S_LFLAG: begin
            go = 1'b1;
            if (!v[0]) begin
              lidx_n = lnext;
              go_step = (lnext < lcount) ? S_LFLAG : S_LOG2FN;
            end else begin
              cidx_n = '0; lscale_n = 8'd8; go_step = S_DELTA;
            end
          end
          S_DELTA: begin
            delta  = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
            nscale = lscale_r + delta;
            if (nscale != '0) lscale_n = nscale;
            cnext  = cidx_r + 1'b1;
            cidx_n = cnext;
            go = 1'b1;
            if (nscale == '0 || cnext >= ((lidx_r < 4'd6) ? 7'd16 : 7'd64)) begin
              lidx_n = lnext;
              go_step = (lnext < lcount) ? S_LFLAG : S_LOG2FN;
            end else go_step = S_DELTA;
          end
          S_LOG2FN: begin go = 1'b1; go_step = S_POCTYPE; end
          S_POCTYPE: begin
            go = 1'b1;
            go_step = (v == '0) ? S_POCLSB : ((v == 16'd1) ? S_DZERO : S_MAXREF);
          end
          S_POCLSB: begin go = 1'b1; go_step = S_MAXREF; end
          S_DZERO:  begin go = 1'b1; go_step = S_OFFNR; end
          S_OFFNR:  begin go = 1'b1; go_step = S_OFFTB; end
          S_OFFTB:  begin go = 1'b1; go_step = S_NCYC; end
          S_NCYC: begin
            if (v > 16'd255) begin emit = 1'b1; emit_st = ST_CODE_ERR; end
            else begin
              fcnt_n = v[7:0];
              go = 1'b1; go_step = (v[7:0] != '0) ? S_CYCOFF : S_MAXREF;
            end
          end
          S_CYCOFF: begin
            fcnt_n = fcnt_r - 1'b1;
            go = 1'b1; go_step = (fcnt_n != '0) ? S_CYCOFF : S_MAXREF;
          end
          S_MAXREF: begin go = 1'b1; go_step = S_GAPS; end
          S_GAPS:   begin go = 1'b1; go_step = S_WIDTH; end
          S_WIDTH:  begin wmbs_n = v + 1'b1; go = 1'b1; go_step = S_HEIGHT; end
          S_HEIGHT: begin hunits_n = v + 1'b1; go = 1'b1; go_step = S_FMO; end
          S_FMO: begin
            go = 1'b1;
            if (v[0]) begin ffmo_n = 1'b1; go_step = S_D8X8; end
            else go_step = S_MBAFF;
          end
          S_MBAFF: begin go = 1'b1; go_step = S_D8X8; end
          S_D8X8:  begin go = 1'b1; go_step = S_CROPF; end
          S_CROPF: begin
            go = 1'b1;
            if (v[0]) begin fcrop_n = 1'b1; go_step = S_CROP0; end
            else go_step = S_VUI;
          end
          S_CROP0: begin crop_n[0] = v; go = 1'b1; go_step = S_CROP1; end
          S_CROP1: begin crop_n[1] = v; go = 1'b1; go_step = S_CROP2; end
          S_CROP2: begin crop_n[2] = v; go = 1'b1; go_step = S_CROP3; end
          S_CROP3: begin crop_n[3] = v; go = 1'b1; go_step = S_VUI; end
          S_VUI: begin
            emit = 1'b1;
            if (17'(wmbs_r) > 17'(MAX_PIC_MBS) || hmbs > 17'(MAX_PIC_MBS) ||
                cw >= wpix || ch >= hpix || wr > 21'(MAX_DIM) || hr > 21'(MAX_DIM)) begin
              emit_st = ST_CODE_ERR;
            end else begin
              emit_st = ST_OK; emit_w = wr[12:0]; emit_h = hr[12:0];
            end
          end
          default: ;
        endcase
      end

      // profile and level as read before any restart
      emit_prof  = prof_n;
      emit_level = level_n;

      // start of the next field
      if (go) begin
        fb = fixed_bits(go_step);
        step_n = go_step; acc_n = '0; zrun_n = '0; cnt_n = fb;
        mode_n = (fb != '0) ? RD_FIXED : RD_PREFIX;
      end
      if (emit) begin
        sent_n = 1'b1; step_n = S_DONE;
      end

      // end of byte, truncation and restart
      bidx_n = bidx_r + 1'b1;
      if (bidx_r == 3'd7 || sent_r || emit) begin
        byte_done = 1'b1;
        bidx_n = '0;
        if (item.last_byte && !sent_r && !emit) begin
          emit = 1'b1; emit_st = ST_TRUNC; emit_w = '0; emit_h = '0;
        end
        if (item.last_byte) begin
          step_n = S_NAL; mode_n = RD_FIXED; cnt_n = 5'd8; zrun_n = '0; acc_n = '0;
          fcnt_n = '0; lidx_n = '0; cidx_n = '0; lscale_n = 8'd8;
          wmbs_n = '0; hunits_n = '0;
          for (int i = 0; i < 4; i++) crop_n[i] = '0;
          fsep_n = 1'b0; ffmo_n = 1'b0; fcrop_n = 1'b0; sent_n = 1'b0;
          prof_n = '0; level_n = '0; chroma_n = 2'd1;
        end
      end
    end
  end

  assign res_valid         = emit;
  assign res.frame_width   = emit_w;
  assign res.frame_height  = emit_h;
  assign res.profile       = emit_prof;
  assign res.level         = emit_level;
  assign res.chroma_format = chroma_r;
  assign res.status        = emit_st;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_NAL; mode_r <= RD_FIXED; cnt_r <= 5'd8; zrun_r <= '0; acc_r <= '0;
      fcnt_r <= '0; lidx_r <= '0; cidx_r <= '0; lscale_r <= 8'd8;
      wmbs_r <= '0; hunits_r <= '0;
      for (int i = 0; i < 4; i++) crop_r[i] <= '0;
      fsep_r <= 1'b0; ffmo_r <= 1'b0; fcrop_r <= 1'b0; sent_r <= 1'b0;
      prof_r <= '0; level_r <= '0; chroma_r <= 2'd1; bidx_r <= '0;
    end else begin
      step_r <= step_n; mode_r <= mode_n; cnt_r <= cnt_n; zrun_r <= zrun_n;
      acc_r <= acc_n; fcnt_r <= fcnt_n; lidx_r <= lidx_n; cidx_r <= cidx_n;
      lscale_r <= lscale_n; wmbs_r <= wmbs_n; hunits_r <= hunits_n;
      for (int i = 0; i < 4; i++) crop_r[i] <= crop_n[i];
      fsep_r <= fsep_n; ffmo_r <= ffmo_n; fcrop_r <= fcrop_n; sent_r <= sent_n;
      prof_r <= prof_n; level_r <= level_n; chroma_r <= chroma_n; bidx_r <= bidx_n;
    end
  end

  // checks
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !sent_r)
    else $error("second result for one nal unit");
  a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (item_valid && !hold && byte_done == (res_valid || bidx_r == 3'd7)))
    else $error("result outside an active cycle or byte not closed");
  a_sent_done: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> step_r == S_DONE)
    else $error("sent flag without done step");

endmodule

// ===== rtl/h264_sps_header_parser_unit.sv =====
// bit engine: one bit a cycle while a byte waits and the output is not held; the rest
//   of a byte is skipped after the result is out; the result shows in the cycle after
//   the deciding bit. The serial bit reader sets the byte rate; a 4-entry byte queue
//   keeps accepting until full while a result waits on the output
// reset: synchronous active-low rst_n clears the queue, output valid and parser state
module h264_sps_header_parser_unit #(
  parameter int MAX_PIC_MBS   = 256,
  parameter int MAX_SPS_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_frame_width,
  output logic [12:0] out_frame_height,
  output logic [7:0]  out_profile,
  output logic [7:0]  out_level,
  output logic [1:0]  out_chroma_format,
  output logic [2:0]  out_status
);
  import hsps_pkg::*;

  hsps_item_t   push_item, head_item;
  logic         head_valid, byte_done, res_valid, hold;
  hsps_result_t res, out_r;
  logic         out_valid_r;

  assign push_item.data_byte = in_data_byte;
  assign push_item.last_byte = in_last_byte;

  // front: byte queue
  hsps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_item (push_item),
    .not_full  (in_ready),
    .pop       (byte_done),
    .not_empty (head_valid),
    .head_item (head_item)
  );

  assign hold = out_valid_r && !out_ready;

  // back: bit-serial parser
  hsps_bit_engine #(
    .MAX_PIC_MBS   (MAX_PIC_MBS),
    .MAX_SPS_COUNT (MAX_SPS_COUNT)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (head_valid),
    .item       (head_item),
    .hold       (hold),
    .byte_done  (byte_done),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_frame_width   = out_r.frame_width;
  assign out_frame_height  = out_r.frame_height;
  assign out_profile       = out_r.profile;
  assign out_level         = out_r.level;
  assign out_chroma_format = out_r.chroma_format;
  assign out_status        = out_r.status;

endmodule

// ===== dv/tb_h264_sps_header_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_h264_sps_header_parser_unit;
  import hsps_pkg::*;

  localparam int MAX_PIC_MBS   = 256;
  localparam int MAX_SPS_COUNT = 32;

  // kinds of generated nal unit
  localparam int K_RANDOM    = 0;
  localparam int K_NOT_SPS   = 1;
  localparam int K_BAD_PROF  = 2;
  localparam int K_BAD_LEVEL = 3;
  localparam int K_BAD_ID    = 4;
  localparam int K_LONG_CODE = 5;
  localparam int K_CHROMA    = 6;
  localparam int K_POC_CYCLE = 7;
  localparam int K_OVERSIZE  = 8;
  localparam int K_CROP_ZERO = 9;
  localparam int K_TRUNC     = 10;
  localparam int K_MAX_SIZE  = 11;
  localparam int K_NOISE     = 12;
  localparam int K_LAST      = 12;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [12:0] out_frame_width;
  logic [12:0] out_frame_height;
  logic [7:0]  out_profile;
  logic [7:0]  out_level;
  logic [1:0]  out_chroma_format;
  logic [2:0]  out_status;

  h264_sps_header_parser_unit #(
    .MAX_PIC_MBS  (MAX_PIC_MBS),
    .MAX_SPS_COUNT(MAX_SPS_COUNT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_width  (out_frame_width),
    .out_frame_height (out_frame_height),
    .out_profile      (out_profile),
    .out_level        (out_level),
    .out_chroma_format(out_chroma_format),
    .out_status       (out_status)
  );

  hsps_item_t   byte_stream[$];
  hsps_result_t sps_results[$];
  int           errors;
  int           nal_count;
  int           result_count;
  int           accepted_count;
  bit           idle_burst;

  // header parser state
  logic [5:0]  p_step;
  int unsigned p_shift, p_zeros, p_accum, p_cycles, p_list, p_coef, p_last_sc, p_next_sc;
  int unsigned p_wmbs, p_hunits, p_flags, p_mode;
  int unsigned p_crop[4];
  logic [7:0]  p_prof, p_level;
  logic [1:0]  p_chroma;
  bit          p_sent, p_fresh;
  hsps_result_t p_res;

  localparam int unsigned F_SEP  = 1;
  localparam int unsigned F_FMO  = 2;
  localparam int unsigned F_CROP = 4;

  function automatic void sps_emit(logic [2:0] st, int unsigned w, int unsigned h);
    p_res.frame_width   = w[12:0];
    p_res.frame_height  = h[12:0];
    p_res.profile       = p_prof;
    p_res.level         = p_level;
    p_res.chroma_format = p_chroma;
    p_res.status        = st;
    p_sent  = 1'b1;
    p_fresh = 1'b1;
    p_step  = S_DONE;
  endfunction

  function automatic void enter_step(logic [5:0] s);
    p_step  = s;
    p_accum = 0;
    p_zeros = 0;
    case (s)
      S_NAL, S_PROFILE, S_CONSTR, S_LEVEL: p_shift = 8;
      S_SEP, S_BYPASS, S_SMP, S_LFLAG, S_DZERO, S_GAPS, S_FMO, S_MBAFF,
      S_D8X8, S_CROPF, S_VUI: p_shift = 1;
      default: p_shift = 0;
    endcase
    p_mode = (p_shift != 0) ? RD_FIXED : RD_PREFIX;
  endfunction

  function automatic void sps_restart();
    p_shift = 0; p_zeros = 0; p_accum = 0; p_cycles = 0;
    p_list = 0; p_coef = 0; p_last_sc = 8; p_next_sc = 8;
    p_wmbs = 0; p_hunits = 0;
    for (int i = 0; i < 4; i++) p_crop[i] = 0;
    p_flags = 0; p_sent = 0;
    p_prof = 0; p_level = 0; p_chroma = 1;
    enter_step(S_NAL);
  endfunction

  function automatic bit high_prof(logic [7:0] p);
    return p == 100 || p == 110 || p == 122 || p == 244;
  endfunction

  function automatic bit known_level(logic [7:0] v);
    case (v)
      9, 10, 11, 12, 13, 20, 21, 22, 30, 31, 32, 40, 41, 42, 50, 51: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // cropped size at the vui flag
  function automatic void size_result();
    int unsigned fmo, hmbs, cux, cuy, w, h, cw, ch;
    fmo  = (p_flags & F_FMO) ? 1 : 0;
    hmbs = p_hunits * (2 - fmo);
    cw = 0;
    ch = 0;
    if (p_wmbs > MAX_PIC_MBS || hmbs > MAX_PIC_MBS) begin
      sps_emit(ST_CODE_ERR, 0, 0);
      return;
    end
    w = 16 * p_wmbs;
    h = 16 * hmbs;
    if (p_chroma == 0 || (p_flags & F_SEP)) begin
      cux = 1; cuy = 2 - fmo;
    end else begin
      cux = (p_chroma == 3) ? 1 : 2;
      cuy = ((p_chroma == 1) ? 2 : 1) * (2 - fmo);
    end
    if (p_flags & F_CROP) begin
      cw = cux * (p_crop[0] + p_crop[1]);
      ch = cuy * (p_crop[2] + p_crop[3]);
    end
    if (cw >= w || ch >= h || w - cw > 4096 || h - ch > 4096) begin
      sps_emit(ST_CODE_ERR, 0, 0);
      return;
    end
    sps_emit(ST_OK, w - cw, h - ch);
  endfunction

  function automatic void scaling_list_done();
    int unsigned count;
    count  = (p_chroma == 3) ? 12 : 8;
    p_list = (p_list + 1) & 15;
    enter_step(p_list < count ? S_LFLAG : S_LOG2FN);
  endfunction

  function automatic void syntax_field(int unsigned v);
    int unsigned delta, size;
    logic [5:0]  s;
    s = p_step;
    case (s)
      S_NAL: begin
        if ((v & 32'h1F) != 7) sps_emit(ST_NOT_SPS, 0, 0);
        else enter_step(S_PROFILE);
      end
      S_PROFILE: begin
        p_prof = v[7:0];
        if (!(high_prof(p_prof) || p_prof == 66 || p_prof == 77 || p_prof == 88))
          sps_emit(ST_BAD_PROF, 0, 0);
        else enter_step(S_CONSTR);
      end
      S_CONSTR: enter_step(S_LEVEL);
      S_LEVEL: begin
        p_level = v[7:0];
        if (!known_level(p_level)) sps_emit(ST_BAD_LEVEL, 0, 0);
        else enter_step(S_SPSID);
      end
      S_SPSID: begin
        if (v > MAX_SPS_COUNT - 1) sps_emit(ST_BAD_ID, 0, 0);
        else enter_step(high_prof(p_prof) ? S_CHROMA : S_LOG2FN);
      end
      S_CHROMA: begin
        if (v > 3) sps_emit(ST_CODE_ERR, 0, 0);
        else begin
          p_chroma = v[1:0];
          enter_step(v == 3 ? S_SEP : S_DEPL);
        end
      end
      S_SEP: begin
        if (v != 0) p_flags |= F_SEP;
        enter_step(S_DEPL);
      end
      S_DEPL:   enter_step(S_DEPC);
      S_DEPC:   enter_step(S_BYPASS);
      S_BYPASS: enter_step(S_SMP);
      S_SMP: begin
        p_list = 0;
        enter_step(v != 0 ? S_LFLAG : S_LOG2FN);
      end
      S_LFLAG: begin
        if (v == 0) scaling_list_done();
        else begin
          p_coef = 0; p_last_sc = 8; p_next_sc = 8;
          enter_step(S_DELTA);
        end
      end
      S_DELTA: begin
        // se mapping, values wrap at 8 bits
        delta = (v & 1) ? ((v >> 1) + 1) : (0 - (v >> 1));
        p_next_sc = (p_last_sc + delta) & 8'hFF;
        if (p_next_sc != 0) p_last_sc = p_next_sc;
        p_coef = (p_coef + 1) & 127;
        size = (p_list < 6) ? 16 : 64;
        if (p_next_sc == 0 || p_coef >= size) scaling_list_done();
        else enter_step(S_DELTA);
      end
      S_LOG2FN:  enter_step(S_POCTYPE);
      S_POCTYPE: enter_step(v == 0 ? S_POCLSB : (v == 1 ? S_DZERO : S_MAXREF));
      S_POCLSB:  enter_step(S_MAXREF);
      S_DZERO:   enter_step(S_OFFNR);
      S_OFFNR:   enter_step(S_OFFTB);
      S_OFFTB:   enter_step(S_NCYC);
      S_NCYC: begin
        if (v > 255) sps_emit(ST_CODE_ERR, 0, 0);
        else begin
          p_cycles = v;
          enter_step(v != 0 ? S_CYCOFF : S_MAXREF);
        end
      end
      S_CYCOFF: begin
        p_cycles = (p_cycles - 1) & 8'hFF;
        enter_step(p_cycles != 0 ? S_CYCOFF : S_MAXREF);
      end
      S_MAXREF: enter_step(S_GAPS);
      S_GAPS:   enter_step(S_WIDTH);
      S_WIDTH: begin
        p_wmbs = (v + 1) & 16'hFFFF;
        enter_step(S_HEIGHT);
      end
      S_HEIGHT: begin
        p_hunits = (v + 1) & 16'hFFFF;
        enter_step(S_FMO);
      end
      S_FMO: begin
        if (v != 0) begin
          p_flags |= F_FMO;
          enter_step(S_D8X8);
        end else enter_step(S_MBAFF);
      end
      S_MBAFF: enter_step(S_D8X8);
      S_D8X8:  enter_step(S_CROPF);
      S_CROPF: begin
        if (v != 0) begin
          p_flags |= F_CROP;
          enter_step(S_CROP0);
        end else enter_step(S_VUI);
      end
      S_CROP0, S_CROP1, S_CROP2, S_CROP3: begin
        p_crop[(s - S_CROP0) & 3] = v & 16'hFFFF;
        enter_step(s == S_CROP3 ? S_VUI : s + 6'd1);
      end
      S_VUI: size_result();
      default: ;
    endcase
  endfunction

  function automatic void sps_bit(bit b);
    if (p_mode == RD_FIXED) begin
      p_accum = (p_accum << 1) | b;
      p_shift--;
      if (p_shift == 0) syntax_field(p_accum);
    end else if (p_mode == RD_PREFIX) begin
      if (!b) begin
        if (p_zeros >= 15) sps_emit(ST_CODE_ERR, 0, 0);
        else p_zeros++;
      end else begin
        p_accum = 1;
        if (p_zeros == 0) syntax_field(0);
        else begin
          p_mode  = RD_SUFFIX;
          p_shift = p_zeros;
        end
      end
    end else begin
      p_accum = (p_accum << 1) | b;
      p_shift--;
      if (p_shift == 0) syntax_field(p_accum - 1);
    end
  endfunction

  // one byte into the parser; returns 1 when a result comes of it
  function automatic bit sps_byte(hsps_item_t it, output hsps_result_t r);
    p_fresh = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (p_sent) break;
      sps_bit(it.data_byte[i]);
    end
    if (it.last_byte && !p_sent) sps_emit(ST_TRUNC, 0, 0);
    r = p_res;
    if (it.last_byte) sps_restart();
    return p_fresh;
  endfunction

  // bit writer for nal construction
  bit nal_bits[$];

  task automatic put_bits(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) nal_bits.push_back(v[i]);
  endtask

  task automatic put_ue(int unsigned v);
    int unsigned x;
    int len;
    x = v + 1;
    len = 0;
    while ((x >> len) != 0) len++;
    put_bits(0, len - 1);
    put_bits(x, len);
  endtask

  task automatic put_se(int d);
    put_ue(d > 0 ? 2 * d - 1 : -2 * d);
  endtask

  function automatic int pick_small();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 3);
    if (r < 9) return $urandom_range(0, 30);
    return $urandom_range(0, 2000);
  endfunction

  task automatic make_nal(int kind);
    int prof_list[7] = '{66, 77, 88, 100, 110, 122, 244};
    int level_list[16] = '{9, 10, 11, 12, 13, 20, 21, 22, 30, 31, 32, 40, 41, 42, 50, 51};
    int prof, chroma, poc, ncyc, lists, size, last, nxt, d, wm, hu, fmo, nbytes;
    bit crop;
    hsps_item_t it;
    nal_bits.delete();
    if (kind == K_NOISE) begin
      nbytes = $urandom_range(1, 6);
      for (int i = 0; i < nbytes; i++) begin
        it.data_byte = 8'($urandom_range(0, 255));
        it.last_byte = (i == nbytes - 1) ? 1'b1 : ($urandom_range(0, 5) == 0);
        byte_stream.push_back(it);
      end
      return;
    end
    nal_count++;
    // nal header and fixed fields
    if (kind == K_NOT_SPS)
      put_bits({3'($urandom_range(0, 7)), 5'($urandom_range(8, 31))}, 8);
    else put_bits({3'($urandom_range(0, 7)), 5'd7}, 8);
    prof = prof_list[$urandom_range(0, 6)];
    if (kind == K_BAD_PROF) prof = $urandom_range(0, 1) ? 0 : 255;
    put_bits(prof, 8);
    put_bits($urandom_range(0, 255), 8);
    put_bits(kind == K_BAD_LEVEL ? ($urandom_range(0, 1) ? 52 : 255)
                                 : level_list[$urandom_range(0, 15)], 8);
    if (kind == K_LONG_CODE) put_bits(0, $urandom_range(16, 20));
    put_ue(kind == K_BAD_ID ? $urandom_range(MAX_SPS_COUNT, MAX_SPS_COUNT + 40)
                            : $urandom_range(0, MAX_SPS_COUNT - 1));
    chroma = 1;
    if (prof == 100 || prof == 110 || prof == 122 || prof == 244) begin
      chroma = (kind == K_CHROMA) ? $urandom_range(4, 9) : $urandom_range(0, 3);
      put_ue(chroma);
      if (chroma == 3) put_bits($urandom_range(0, 1), 1);
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      put_bits($urandom_range(0, 1), 1);
      if ($urandom_range(0, 3) == 0) begin
        put_bits(1, 1);
        lists = (chroma == 3) ? 12 : 8;
        for (int l = 0; l < lists; l++) begin
          if ($urandom_range(0, 2) == 0) begin
            put_bits(0, 1);
            continue;
          end
          put_bits(1, 1);
          size = (l < 6) ? 16 : 64;
          last = 8;
          for (int j = 0; j < size; j++) begin
            case ($urandom_range(0, 9))
              0: d = -last;
              1: d = $urandom_range(0, 255) - 128;
              2, 3: d = $urandom_range(0, 6) - 3;
              default: d = 0;
            endcase
            if (j >= 4 && $urandom_range(0, 3) == 0) d = -last;
            put_se(d);
            nxt = (last + d) & 255;
            if (nxt == 0) break;
            last = nxt;
          end
        end
      end else put_bits(0, 1);
    end
    // picture order count
    put_ue($urandom_range(0, 12));
    poc = $urandom_range(0, 9);
    poc = (poc < 4) ? 0 : (poc < 7) ? 1 : (poc < 9) ? 2 : $urandom_range(3, 6);
    if (kind == K_POC_CYCLE) poc = 1;
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(0, 12));
    else if (poc == 1) begin
      put_bits($urandom_range(0, 1), 1);
      put_se(pick_small() - 15);
      put_se(pick_small() - 15);
      ncyc = (kind == K_POC_CYCLE) ? $urandom_range(256, 300) : $urandom_range(0, 4);
      put_ue(ncyc);
      if (ncyc < 256) for (int i = 0; i < ncyc; i++) put_se(pick_small() - 15);
    end
    put_ue($urandom_range(0, 16));
    put_bits($urandom_range(0, 1), 1);
    // picture size and cropping
    wm  = $urandom_range(1, 20);
    hu  = $urandom_range(1, 12);
    fmo = $urandom_range(0, 1);
    if (kind == K_MAX_SIZE) begin
      wm = MAX_PIC_MBS; hu = $urandom_range(0, 1) ? MAX_PIC_MBS : MAX_PIC_MBS / 2;
      fmo = (hu == MAX_PIC_MBS) ? 1 : 0;
    end
    if (kind == K_OVERSIZE) begin
      if ($urandom_range(0, 1)) wm = $urandom_range(MAX_PIC_MBS + 1, 400);
      else begin
        hu = $urandom_range(MAX_PIC_MBS / 2 + 1, 200);
        fmo = 0;
      end
    end
    put_ue(wm - 1);
    put_ue(hu - 1);
    put_bits(fmo, 1);
    if (!fmo) put_bits($urandom_range(0, 1), 1);
    put_bits($urandom_range(0, 1), 1);
    crop = (kind == K_CROP_ZERO) || ($urandom_range(0, 2) == 0);
    put_bits(crop, 1);
    if (crop) begin
      for (int i = 0; i < 4; i++) begin
        if (kind == K_CROP_ZERO && i == 0) put_ue($urandom_range(8 * wm, 8 * wm + 20));
        else put_ue($urandom_range(0, 3));
      end
    end
    put_bits($urandom_range(0, 1), 1);
    // trailing bits that the parser ignores
    put_bits($urandom_range(0, 65535), $urandom_range(0, 16));
    while (nal_bits.size() % 8 != 0) nal_bits.push_back(1'($urandom_range(0, 1)));
    nbytes = nal_bits.size() / 8;
    if (kind == K_TRUNC) nbytes = $urandom_range(1, nbytes - 1);
    for (int i = 0; i < nbytes; i++) begin
      for (int b = 0; b < 8; b++) it.data_byte[7 - b] = nal_bits[8 * i + b];
      it.last_byte = (i == nbytes - 1);
      byte_stream.push_back(it);
    end
  endtask

  function automatic int gap_len();
    int r;
    if (idle_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte driver
  int in_gap;
  always @(posedge clk) begin
    hsps_item_t   cur;
    hsps_result_t r;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= '0;
      in_last_byte <= 1'b0;
      in_gap       = 0;
    end else begin
      if (in_valid && in_ready) begin
        cur.data_byte = in_data_byte;
        cur.last_byte = in_last_byte;
        if (sps_byte(cur, r)) sps_results.push_back(r);
        accepted_count++;
        if (accepted_count % 200 == 0) idle_burst = ~idle_burst;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          cur = byte_stream.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= cur.data_byte;
          in_last_byte <= cur.last_byte;
          in_gap       = gap_len();
        end else in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  int out_gap;
  always @(posedge clk) begin
    hsps_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (sps_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errors++;
        end else begin
          e = sps_results.pop_front();
          if (out_frame_width !== e.frame_width) begin
            $error("frame_width expected %0d actual %0d", e.frame_width, out_frame_width);
            errors++;
          end
          if (out_frame_height !== e.frame_height) begin
            $error("frame_height expected %0d actual %0d", e.frame_height, out_frame_height);
            errors++;
          end
          if (out_profile !== e.profile) begin
            $error("profile expected %0d actual %0d", e.profile, out_profile);
            errors++;
          end
          if (out_level !== e.level) begin
            $error("level expected %0d actual %0d", e.level, out_level);
            errors++;
          end
          if (out_chroma_format !== e.chroma_format) begin
            $error("chroma_format expected %0d actual %0d", e.chroma_format,
                   out_chroma_format);
            errors++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap   = gap_len();
      end
    end
  end

  // stimulus and end of run
  initial begin
    errors = 0; nal_count = 0; result_count = 0; accepted_count = 0;
    idle_burst = 1'b0;
    in_valid = 1'b0; in_data_byte = '0; in_last_byte = 1'b0; out_ready = 1'b0;
    sps_restart();
    p_res = '0;
    rst_n = 1'b0;
    // directed: each special case once and the maximum size twice, then a few plain headers
    for (int k = 1; k <= K_LAST; k++) make_nal(k);
    make_nal(K_MAX_SIZE);
    for (int i = 0; i < 4; i++) make_nal(K_RANDOM);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // random: mostly well-formed headers, some broken ones and noise
    while (byte_stream.size() + accepted_count < 1300) begin
      if ($urandom_range(0, 3) != 0) make_nal(K_RANDOM);
      else make_nal($urandom_range(1, K_LAST));
    end
    wait (byte_stream.size() == 0 && !in_valid);
    wait (sps_results.size() == 0);
    repeat (100) @(posedge clk);
    if (sps_results.size() != 0) begin
      $error("%0d expected results never arrived", sps_results.size());
      errors++;
    end
    $display("run covered %0d bytes in %0d sps units, %0d results checked",
             accepted_count, nal_count, result_count);
    $display("including malformed units, truncation, oversize and crop errors, noise bytes");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== h264_sps_header_parser_unit.f =====
rtl/hsps_pkg.sv
rtl/hsps_queue.sv
rtl/hsps_bit_engine.sv
rtl/h264_sps_header_parser_unit.sv
dv/tb_h264_sps_header_parser_unit.sv
